[hdl/firlp_pkg.sv]
// Package for the 21-tap low-pass FIR: widths, coefficient table and lookup.
`timescale 1ns / 1ps
package firlp_pkg;

  localparam int TAPS_DEF    = 21;
  localparam int SAMPLE_BITS = 12;
  localparam int COEF_BITS   = 16;
  localparam int HALF_LEN    = 11;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic [SAMPLE_BITS-1:0]      sample_t;

  // Symmetric Q1.15 taps; entries past the centre mirror, beyond it use the centre.
  function automatic coef_t coef_at(input int k, input int taps);
    int    m;
    coef_t c;
    m = (k < taps - 1 - k) ? k : taps - 1 - k;
    if (m >= HALF_LEN) m = HALF_LEN - 1;
    if (m < 0) m = 0;
    case (m)
      0:       c = -16'sd1990;
      1:       c = -16'sd319;
      2:       c = 16'sd1165;
      3:       c = -16'sd2115;
      4:       c = 16'sd2593;
      5:       c = -16'sd2086;
      6:       c = 16'sd399;
      7:       c = 16'sd2199;
      8:       c = -16'sd5024;
      9:       c = 16'sd7207;
      default: c = 16'sd24742;
    endcase
    return c;
  endfunction

endpackage

[hdl/firlp_in_if.sv]
// Sample input channel: valid/ready handshake with one ADC sample.
`timescale 1ns / 1ps
interface firlp_in_if
  import firlp_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[hdl/firlp_out_if.sv]
// Result channel: valid/ready handshake with filtered value and clamp flag.
`timescale 1ns / 1ps
interface firlp_out_if
  import firlp_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t filtered;
  logic    clamped;

  modport source (output valid, output filtered, output clamped, input ready);
  modport sink   (input valid, input filtered, input clamped, output ready);
endinterface

[hdl/firlp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module firlp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 21,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/fir_lowpass_21tap.sv]
// Top level of the 21-tap symmetric low-pass FIR filter on 12-bit samples.
//
// Usage:
//   in_ch  (sink):   one 12-bit ADC sample per transfer (valid/ready).
//   out_ch (source): filtered 12-bit value, rounded half up and clamped to
//                    0..4095, plus a flag set when clamping took place.
//   Each sample is written into a circular delay line held in a RAM, then the
//   taps are read back one per cycle and put through a single multiplier and
//   accumulator. The rate is set by the one RAM read port and the single MAC,
//   so a new sample is taken only after the last one has been swept, drained
//   and turned into a result.
//   in_ch.ready is high only while the datapath is idle; the result sits in an
//   output register, so the next sample can be taken while it waits.
//   If the receiver stalls, the filter finishes the next item and holds it
//   until the output register frees up.
//   Reset (rst_n low, synchronous) clears the delay-line valid bits, so all
//   taps read as zero, and returns the write position to zero. No clearing
//   pass is needed.
`timescale 1ns / 1ps
module fir_lowpass_21tap
  import firlp_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  firlp_in_if.sink    in_ch,
  firlp_out_if.source out_ch
);

  localparam int PW     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int KW     = $clog2(TAPS + 1);
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS + 1;
  localparam int ACC_W  = PROD_W + KW + 1;
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) <<< (COEF_BITS - 2);
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((1 << SAMPLE_BITS) - 1);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN, S_FIN} state_t;

  state_t                    state_r, state_nxt;
  logic [PW-1:0]             pos_r, pos_nxt;
  logic [PW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [KW-1:0]             k_r, k_nxt;
  logic [TAPS-1:0]           vbit_r, vbit_nxt;
  logic                      d1_vld_r, d1_vld_nxt;
  logic                      d1_ok_r, d1_ok_nxt;
  logic [KW-1:0]             d1_k_r, d1_k_nxt;
  logic                      p_vld_r, p_vld_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      out_vld_r, out_vld_nxt;
  sample_t                   out_filt_r, out_filt_nxt;
  logic                      out_clmp_r, out_clmp_nxt;

  logic                      in_xfer;
  logic                      out_free;
  sample_t                   ram_rdata;
  logic signed [SAMPLE_BITS:0] tap_s;
  coef_t                     tap_coef;
  logic signed [ACC_W-1:0]   rounded;
  logic signed [ACC_W-1:0]   scaled;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_xfer         = in_ch.valid && in_ch.ready;
  assign out_free        = !out_vld_r || out_ch.ready;
  assign out_ch.valid    = out_vld_r;
  assign out_ch.filtered = out_filt_r;
  assign out_ch.clamped  = out_clmp_r;

  firlp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_dline (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (pos_r),
    .wdata (in_ch.sample),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // Entries never written since reset read as zero.
  assign tap_s    = d1_ok_r ? $signed({1'b0, ram_rdata}) : '0;
  assign tap_coef = coef_at(int'(d1_k_r), TAPS);
  assign rounded  = acc_r + RND;
  assign scaled   = rounded >>> (COEF_BITS - 1);

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    rd_idx_nxt   = rd_idx_r;
    k_nxt        = k_r;
    vbit_nxt     = vbit_r;
    d1_vld_nxt   = 1'b0;
    d1_ok_nxt    = d1_ok_r;
    d1_k_nxt     = d1_k_r;
    p_vld_nxt    = d1_vld_r;
    prod_nxt     = PROD_W'(tap_s) * PROD_W'(tap_coef);
    acc_nxt      = p_vld_r ? acc_r + ACC_W'(prod_r) : acc_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_filt_nxt = out_filt_r;
    out_clmp_nxt = out_clmp_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          vbit_nxt[pos_r] = 1'b1;
          rd_idx_nxt      = pos_r;
          k_nxt           = '0;
          acc_nxt         = '0;
          pos_nxt         = (pos_r == PW'(TAPS - 1)) ? '0 : pos_r + PW'(1);
          state_nxt       = S_ISSUE;
        end
      end
      S_ISSUE: begin
        // One tap read per cycle, walking backwards round the delay line.
        d1_vld_nxt = 1'b1;
        d1_ok_nxt  = vbit_r[rd_idx_r];
        d1_k_nxt   = k_r;
        rd_idx_nxt = (rd_idx_r == '0) ? PW'(TAPS - 1) : rd_idx_r - PW'(1);
        k_nxt      = k_r + KW'(1);
        if (k_r == KW'(TAPS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!d1_vld_r && !p_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          if (rounded < 0) begin
            out_filt_nxt = '0;
            out_clmp_nxt = 1'b1;
          end else if (scaled > SMAX) begin
            out_filt_nxt = SMAX[SAMPLE_BITS-1:0];
            out_clmp_nxt = 1'b1;
          end else begin
            out_filt_nxt = scaled[SAMPLE_BITS-1:0];
            out_clmp_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      vbit_r    <= '0;
      d1_vld_r  <= 1'b0;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      vbit_r    <= vbit_nxt;
      d1_vld_r  <= d1_vld_nxt;
      p_vld_r   <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    rd_idx_r   <= rd_idx_nxt;
    k_r        <= k_nxt;
    d1_ok_r    <= d1_ok_nxt;
    d1_k_r     <= d1_k_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_filt_r <= out_filt_nxt;
    out_clmp_r <= out_clmp_nxt;
  end

`ifndef SYNTHESIS
  a_accept_starts_issue : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_ISSUE) && (k_r == '0))
    else $error("transfer in did not start the tap sweep");

  a_pos_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(TAPS - 1))
    else $error("write position left the delay line");

  a_idle_no_work : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !d1_vld_r && !p_vld_r)
    else $error("MAC pipeline busy while ready for a new sample");

  a_fin_drained : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> !d1_vld_r && !p_vld_r)
    else $error("result formed before accumulation finished");
`endif

endmodule
